// ----- rtl/fmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// fmpd_pkg: shared types and constants
// Sequencer states, divider status and register indexes of the FM stereo
// pilot doubler.
// ----------------------------------------------------------------------------
package fmpd_pkg;

    // Register indexes of the configuration port
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_STEP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_STEP = 1'b1;

    // Fraction bits of x and y never exceed this cap
    localparam int XY_FRAC_CAP = 22;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_NUM,
        ST_CHECK,
        ST_DIV,
        ST_SAT,
        ST_MUL_OUT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/fm_stereo_pilot_doubler_core.sv -----
// ----------------------------------------------------------------------------
// fm_stereo_pilot_doubler_core: pilot-doubling stereo difference demodulator
// Forms the 38 kHz carrier from the 19 kHz pilot with a shared multiplier and
// a restoring divider, and mixes the subchannel sample down with it.
// ----------------------------------------------------------------------------
// Write sin_step (index 0) and cos_step (index 1) on the cfg_ port while the
// block is idle. Each s_ transaction carries one MPX sample (pilot in the low
// half of s_tdata, subchannel above it) and yields one difference sample on m_.
// The sequence runs seven multiplier and setup steps, a divide step in which
// the divider forms SAMPLE_WIDTH-1 quotient bits, one a cycle, and three
// steps of saturation and output mixing. A new sample is taken only once the
// previous one has left the sequencer. A zero denominator or a full-scale
// quotient skips the divider.
// s_tready is high only while the sequencer is idle. The result waits in an
// output register, so the next sample is taken meanwhile; if m_tready stays
// low the sequencer holds the following result until the register frees up.
// Reset clears the previous pilot sample, sets sin_step to 0 and cos_step to
// full scale, and empties the output register.
// ----------------------------------------------------------------------------
module fm_stereo_pilot_doubler_core
    import fmpd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]                    cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]                   cfg_data,
    // input samples
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // s_tdata: pilot, subchannel
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // output samples
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // m_tdata: difference_sample
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata
);

    localparam int W        = SAMPLE_WIDTH;
    localparam int FRAC     = W - 1;
    localparam int XY_FRAC  = (2 * FRAC < XY_FRAC_CAP) ? 2 * FRAC : XY_FRAC_CAP;
    localparam int XY_SHIFT = 2 * FRAC - XY_FRAC;
    localparam int XW       = XY_FRAC + 2;
    localparam int YW       = XY_FRAC + 3;
    localparam int MW       = (W > YW) ? W : YW;
    localparam int PW       = 2 * MW;
    localparam int DW       = 2 * XY_FRAC + 3;
    localparam int OUT_TW   = ((W + 7) / 8) * 8;

    localparam logic signed [W-1:0] SMAX = {1'b0, {FRAC{1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {FRAC{1'b0}}};

    state_t state_reg;
    state_t state_next;

    logic signed [W-1:0]  sin_reg;
    logic signed [W-1:0]  cos_reg;
    logic signed [W-1:0]  prev_reg;
    logic signed [W-1:0]  p_reg;
    logic signed [W-1:0]  s_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [YW-1:0] y_reg;
    logic [DW-1:0]        den_reg;
    logic [DW-1:0]        num_reg;
    logic                 neg_reg;
    logic [FRAC:0]        mag_reg;
    logic signed [W-1:0]  d_reg;
    logic signed [W-1:0]  out_data_reg;
    logic                 out_valid_reg;

    logic                 mul_en;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    logic                 div_start;
    logic [FRAC-1:0]      quotient;
    div_status_t          div_stat;

    logic                 in_take;
    logic                 out_free;
    logic signed [PW-1:0] prod_xy;
    logic signed [PW-1:0] q_wide;
    logic signed [PW-1:0] q_term;
    logic signed [PW-1:0] y_full;
    logic signed [PW-1:0] prod_abs;
    logic signed [W:0]    d_full;
    logic signed [PW-1:0] prod_out;

    fmpd_mul #(
        .MW(MW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .prod(prod)
    );

    fmpd_div #(
        .DW    (DW),
        .Q_BITS(FRAC)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .quotient(quotient),
        .status  (div_stat)
    );

    assign in_take  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Datapath helpers
    assign prod_xy  = prod >>> XY_SHIFT;
    assign q_wide   = PW'(prev_reg);
    assign q_term   = (q_wide <<< FRAC) >>> XY_SHIFT;
    assign y_full   = prod_xy - q_term;
    assign prod_abs = prod[PW-1] ? -prod : prod;
    assign d_full   = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign prod_out = prod >>> FRAC;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:   state_next = ST_MUL_Y;
            ST_MUL_Y:   state_next = ST_MUL_XX;
            ST_MUL_XX:  state_next = ST_MUL_YY;
            ST_MUL_YY:  state_next = ST_MUL_XY;
            ST_MUL_XY:  state_next = ST_NUM;
            ST_NUM:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (den_reg == '0 || num_reg >= den_reg)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:     state_next = ST_MUL_OUT;
            ST_MUL_OUT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, divider start and s_tready
    always_comb
    begin
        mul_en    = 1'b0;
        mul_a     = MW'(p_reg);
        mul_b     = MW'(sin_reg);
        div_start = 1'b0;
        s_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_MUL_X:
            begin
                mul_en = 1'b1;
            end
            ST_MUL_Y:
            begin
                mul_en = 1'b1;
                mul_b  = MW'(cos_reg);
            end
            ST_MUL_XX:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(x_reg);
                mul_b  = MW'(x_reg);
            end
            ST_MUL_YY:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(y_reg);
                mul_b  = MW'(y_reg);
            end
            ST_MUL_XY:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(x_reg);
                mul_b  = MW'(y_reg);
            end
            ST_CHECK:
            begin
                div_start = (den_reg != '0) && (num_reg < den_reg);
            end
            ST_MUL_OUT:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(s_reg);
                mul_b  = MW'(d_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sin_reg       <= '0;
            cos_reg       <= SMAX;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIN_STEP: sin_reg <= cfg_data;
                    REG_COS_STEP: cos_reg <= cfg_data;
                    default:      sin_reg <= sin_reg;
                endcase
            end
            // q is consumed when y is captured; advance it there
            if (state_reg == ST_MUL_XX)
            begin
                prev_reg <= p_reg;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            p_reg <= s_tdata[W-1:0];
            s_reg <= s_tdata[2*W-1:W];
        end
        case (state_reg)
            ST_MUL_Y:
            begin
                x_reg <= prod_xy[XW-1:0];
            end
            ST_MUL_XX:
            begin
                y_reg <= y_full[YW-1:0];
            end
            ST_MUL_YY:
            begin
                den_reg <= prod[DW-1:0];
            end
            ST_MUL_XY:
            begin
                den_reg <= den_reg + prod[DW-1:0];
            end
            ST_NUM:
            begin
                num_reg <= {prod_abs[DW-2:0], 1'b0};
                neg_reg <= prod[PW-1];
            end
            ST_CHECK:
            begin
                if (den_reg == '0)
                begin
                    mag_reg <= '0;
                end
                else
                begin
                    mag_reg <= {1'b1, {FRAC{1'b0}}};
                end
            end
            ST_DIV:
            begin
                mag_reg <= {1'b0, quotient};
            end
            ST_SAT:
            begin
                if (d_full > $signed((W + 1)'(SMAX)))
                begin
                    d_reg <= SMAX;
                end
                else
                begin
                    d_reg <= d_full[W-1:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (prod_out > PW'(SMAX))
                    begin
                        out_data_reg <= SMAX;
                    end
                    else if (prod_out < PW'(SMIN))
                    begin
                        out_data_reg <= SMIN;
                    end
                    else
                    begin
                        out_data_reg <= prod_out[W-1:0];
                    end
                end
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'($unsigned(out_data_reg));

`ifndef SYNTHESIS
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_MUL_X) && !s_tready)
        else $error("accepted transaction did not start the sequence");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && den_reg == '0) |=> mag_reg == '0 && state_reg == ST_SAT)
        else $error("zero denominator did not force a zero carrier");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> m_tvalid && state_reg == ST_IDLE)
        else $error("finished result not presented");
`endif

endmodule

// ----- rtl/fmpd_mul.sv -----
// ----------------------------------------------------------------------------
// fmpd_mul: shared signed multiplier
// One signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module fmpd_mul #(
    parameter int MW = 25
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] prod
);

    logic signed [2*MW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/fmpd_div.sv -----
// ----------------------------------------------------------------------------
// fmpd_div: restoring divider
// Computes floor(num * 2^Q_BITS / den) for num < den, one quotient bit a
// cycle.
// ----------------------------------------------------------------------------
module fmpd_div
    import fmpd_pkg::*;
#(
    parameter int DW     = 47,
    parameter int Q_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     num,
    input  logic [DW-1:0]     den,
    output logic [Q_BITS-1:0] quotient,
    output div_status_t       status
);

    localparam int CW = $clog2(Q_BITS + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic              done_next;
    logic [DW:0]       rem_reg;
    logic [DW:0]       rem_next;
    logic [Q_BITS-1:0] quo_reg;
    logic [Q_BITS-1:0] quo_next;
    logic [DW:0]       rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg[DW-1:0], 1'b0};
    assign fits      = rem_shift >= {1'b0, den};

    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        if (start)
        begin
            count_next = CW'(Q_BITS);
            rem_next   = {1'b0, num};
            quo_next   = '0;
        end
        else if (count_reg != '0)
        begin
            rem_next   = fits ? (rem_shift - {1'b0, den}) : rem_shift;
            quo_next   = {quo_reg[Q_BITS-2:0], fits};
            count_next = count_reg - CW'(1);
            done_next  = (count_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = (count_reg != '0);
    assign status.done = done_reg;

endmodule
